@@ sv/dofifo_pkg.sv @@
`default_nettype none
package dofifo_pkg;

	localparam int DEPTH_DEF       = 4096;
	localparam int BLOCK_SIZE_DEF  = 126;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int IQ_W    = 16;
	localparam int BATCH_W = 16;
	localparam int FILL_W  = 13;
	localparam int TOTAL_W = 48;

	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic push;
		logic clear;
		logic status;
		logic underrun;
		logic pop_take;
		logic rd_even;
		logic rd_odd;
		logic latch_even;
		logic load_pair;
		logic pair_last;
		logic pair_odd;
	} dofifo_cmd_t;

	typedef struct packed {
		logic short_block;
		logic out_free;
	} dofifo_sts_t;

endpackage
`default_nettype wire

@@ sv/dofifo_ram.sv @@
`default_nettype none
module dofifo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ sv/dofifo_ctrl.sv @@
`default_nettype none
module dofifo_ctrl #(
	parameter int BLOCK_SIZE = dofifo_pkg::BLOCK_SIZE_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              mode,
	input  wire dofifo_pkg::dofifo_sts_t sts,
	output dofifo_pkg::dofifo_cmd_t      cmd
);

	localparam int NPAIRS = (BLOCK_SIZE + 1) / 2;
	localparam int PAIR_W = NPAIRS > 1 ? $clog2(NPAIRS) : 1;
	localparam bit ODD_BS = (BLOCK_SIZE % 2) == 1;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_RD_EVEN = 2'd1;
	localparam logic [1:0] ST_RD_ODD  = 2'd2;
	localparam logic [1:0] ST_LOAD    = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [PAIR_W-1:0] k_q, k_d;
	logic              in_fire;
	logic              is_last;

	assign in_stall = !((state_q == ST_IDLE) && sts.out_free);
	assign in_fire  = in_valid && !in_stall;
	assign is_last  = (32'(k_q) == 32'(NPAIRS - 1));

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		cmd     = '0;
		cmd.pair_last = is_last;
		cmd.pair_odd  = !(is_last && ODD_BS);
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (mode)
						dofifo_pkg::MODE_PUSH: begin
							cmd.push = 1'b1;
						end
						dofifo_pkg::MODE_POP: begin
							if (sts.short_block) begin
								cmd.underrun = 1'b1;
							end else begin
								cmd.pop_take = 1'b1;
								k_d          = '0;
								state_d      = ST_RD_EVEN;
							end
						end
						dofifo_pkg::MODE_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
							cmd.status = 1'b1;
						end
					endcase
				end
			end
			ST_RD_EVEN: begin
				cmd.rd_even = 1'b1;
				state_d     = ST_RD_ODD;
			end
			ST_RD_ODD: begin
				cmd.latch_even = 1'b1;
				cmd.rd_odd     = cmd.pair_odd;
				state_d        = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load_pair = 1'b1;
					if (is_last) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = ST_RD_EVEN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/dofifo_dpath.sv @@
`default_nettype none
module dofifo_dpath #(
	parameter int DEPTH       = dofifo_pkg::DEPTH_DEF,
	parameter int BLOCK_SIZE  = dofifo_pkg::BLOCK_SIZE_DEF,
	parameter int SAMPLE_BITS = dofifo_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire dofifo_pkg::dofifo_cmd_t              cmd,
	output dofifo_pkg::dofifo_sts_t                   sts,
	input  wire logic signed [dofifo_pkg::IQ_W-1:0]   in_i,
	input  wire logic signed [dofifo_pkg::IQ_W-1:0]   in_q,
	input  wire logic                                 batch_end,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      pop_ok,
	output logic                                      underrun,
	output logic signed [dofifo_pkg::IQ_W-1:0]        even_i,
	output logic signed [dofifo_pkg::IQ_W-1:0]        even_q,
	output logic signed [dofifo_pkg::IQ_W-1:0]        odd_i,
	output logic signed [dofifo_pkg::IQ_W-1:0]        odd_q,
	output logic                                      last,
	output logic                                      dropped_now,
	output logic [dofifo_pkg::BATCH_W-1:0]            batch_dropped,
	output logic [dofifo_pkg::FILL_W-1:0]             fill_level,
	output logic [dofifo_pkg::TOTAL_W-1:0]            lifetime_dropped
);

	localparam int IQ_W    = dofifo_pkg::IQ_W;
	localparam int SB      = SAMPLE_BITS;
	localparam int PTR_W   = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ENTRY_W = 2 * SB;

	logic [PTR_W-1:0]              wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0]              held_q, held_d, held_push;
	logic [dofifo_pkg::BATCH_W-1:0] batch_q, batch_d, batch_new;
	logic [dofifo_pkg::TOTAL_W-1:0] total_q, total_d, total_new;
	logic                          out_valid_q;
	logic                          full;
	logic                          out_load;
	logic [31:0]                   held_d32;

	logic [ENTRY_W-1:0]            wr_entry, rd_data, even_raw_q;
	logic [SB-1:0]                 sat_lane [2];
	logic [IQ_W-1:0]               in_lane [2];
	logic [SB-1:0]                 rd_lane [4];
	logic [IQ_W-1:0]               ext_lane [4];
	logic [PTR_W-1:0]              rd_addr;

	logic                          pop_ok_q, underrun_q, last_q, dropped_q;
	logic [IQ_W-1:0]               even_i_q, even_q_q, odd_i_q, odd_q_q;
	logic [dofifo_pkg::BATCH_W-1:0] batch_out_q;
	logic [dofifo_pkg::FILL_W-1:0]  fill_q;
	logic [dofifo_pkg::TOTAL_W-1:0] total_out_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (32'(p) == 32'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// saturate pushed samples to the stored width
	assign in_lane[0] = in_i;
	assign in_lane[1] = in_q;
	for (genvar g = 0; g < 2; g++) begin : g_sat
		if (SB >= IQ_W) begin : g_wide
			assign sat_lane[g] = SB'($signed(in_lane[g]));
		end else begin : g_narrow
			logic fits;
			assign fits = (in_lane[g][IQ_W-1:SB-1] == '0) || (in_lane[g][IQ_W-1:SB-1] == '1);
			assign sat_lane[g] = fits ? in_lane[g][SB-1:0] :
				(in_lane[g][IQ_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});
		end
	end
	assign wr_entry = {sat_lane[1], sat_lane[0]};

	// lanes: even i, even q, odd i, odd q
	assign rd_lane[0] = even_raw_q[SB-1:0];
	assign rd_lane[1] = even_raw_q[ENTRY_W-1:SB];
	assign rd_lane[2] = rd_data[SB-1:0];
	assign rd_lane[3] = rd_data[ENTRY_W-1:SB];
	for (genvar g = 0; g < 4; g++) begin : g_ext
		if (SB >= IQ_W) begin : g_wide
			assign ext_lane[g] = rd_lane[g][IQ_W-1:0];
		end else begin : g_narrow
			assign ext_lane[g] = {{(IQ_W-SB){rd_lane[g][SB-1]}}, rd_lane[g]};
		end
	end

	assign rd_addr = rd_ptr_q;

	dofifo_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (wr_ptr_q),
		.wr_data (wr_entry),
		.rd_en   (cmd.rd_even | cmd.rd_odd),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign full      = 32'(held_q) >= 32'(DEPTH);
	assign held_push = full ? held_q : held_q + 1'b1;
	assign batch_new = (full && (batch_q != '1)) ? batch_q + 1'b1 : batch_q;
	assign total_new = (full && (total_q != '1)) ? total_q + 1'b1 : total_q;

	assign sts.short_block = 32'(held_q) < 32'(BLOCK_SIZE);
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_load = cmd.push | cmd.clear | cmd.status | cmd.underrun | cmd.load_pair;

	always_comb begin
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		held_d   = held_q;
		batch_d  = batch_q;
		total_d  = total_q;
		if (cmd.push) begin
			wr_ptr_d = next_ptr(wr_ptr_q);
			held_d   = held_push;
			total_d  = total_new;
			batch_d  = batch_end ? '0 : batch_new;
			if (full) begin
				rd_ptr_d = next_ptr(rd_ptr_q);
			end
		end
		if (cmd.clear) begin
			wr_ptr_d = '0;
			rd_ptr_d = '0;
			held_d   = '0;
		end
		if (cmd.pop_take) begin
			held_d = held_q - CNT_W'(BLOCK_SIZE);
		end
		if (cmd.rd_even | cmd.rd_odd) begin
			rd_ptr_d = next_ptr(rd_ptr_q);
		end
	end

	assign held_d32 = 32'(held_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			held_q      <= '0;
			batch_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			held_q   <= held_d;
			batch_q  <= batch_d;
			total_q  <= total_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_even) begin
			even_raw_q <= rd_data;
		end
		if (out_load) begin
			pop_ok_q    <= cmd.load_pair;
			underrun_q  <= cmd.underrun;
			last_q      <= cmd.pair_last | !cmd.load_pair;
			dropped_q   <= cmd.push & full;
			batch_out_q <= cmd.push ? batch_new : batch_q;
			fill_q      <= held_d32[dofifo_pkg::FILL_W-1:0];
			total_out_q <= total_d;
			even_i_q    <= cmd.load_pair ? ext_lane[0] : '0;
			even_q_q    <= cmd.load_pair ? ext_lane[1] : '0;
			odd_i_q     <= (cmd.load_pair && cmd.pair_odd) ? ext_lane[2] : '0;
			odd_q_q     <= (cmd.load_pair && cmd.pair_odd) ? ext_lane[3] : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign pop_ok           = pop_ok_q;
	assign underrun         = underrun_q;
	assign even_i           = even_i_q;
	assign even_q           = even_q_q;
	assign odd_i            = odd_i_q;
	assign odd_q            = odd_q_q;
	assign last             = last_q;
	assign dropped_now      = dropped_q;
	assign batch_dropped    = batch_out_q;
	assign fill_level       = fill_q;
	assign lifetime_dropped = total_out_q;

endmodule
`default_nettype wire

@@ sv/drop_oldest_iq_block_fifo_core.sv @@
// Ring FIFO of I/Q samples that drops the oldest sample when a push finds it full.
// Push, clear and unused-mode transactions each give one result, so pushes stream at one
// per cycle while the output register is free. A pop takes a block of BLOCK_SIZE samples
// out as (BLOCK_SIZE+1)/2 pair results; each pair passes through the read-even, read-odd
// and load states because the sample RAM has one registered read port, and no new
// transaction is taken until the last pair is loaded. A pop finding fewer than
// BLOCK_SIZE samples gives one underrun result. Every result carries the per-batch
// drop count, the fill level after the step and the saturating lifetime drop total.
// The sample RAM needs no clearing after reset.
`default_nettype none
module drop_oldest_iq_block_fifo_core #(
	parameter int DEPTH       = dofifo_pkg::DEPTH_DEF,
	parameter int BLOCK_SIZE  = dofifo_pkg::BLOCK_SIZE_DEF,
	parameter int SAMPLE_BITS = dofifo_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         mode,
	input  wire logic signed [dofifo_pkg::IQ_W-1:0] in_i,
	input  wire logic signed [dofifo_pkg::IQ_W-1:0] in_q,
	input  wire logic                               batch_end,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    pop_ok,
	output logic                                    underrun,
	output logic signed [dofifo_pkg::IQ_W-1:0]      even_i,
	output logic signed [dofifo_pkg::IQ_W-1:0]      even_q,
	output logic signed [dofifo_pkg::IQ_W-1:0]      odd_i,
	output logic signed [dofifo_pkg::IQ_W-1:0]      odd_q,
	output logic                                    last,
	output logic                                    dropped_now,
	output logic [dofifo_pkg::BATCH_W-1:0]          batch_dropped,
	output logic [dofifo_pkg::FILL_W-1:0]           fill_level,
	output logic [dofifo_pkg::TOTAL_W-1:0]          lifetime_dropped
);

	dofifo_pkg::dofifo_cmd_t cmd;
	dofifo_pkg::dofifo_sts_t sts;

	dofifo_ctrl #(
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	dofifo_dpath #(
		.DEPTH       (DEPTH),
		.BLOCK_SIZE  (BLOCK_SIZE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_i             (in_i),
		.in_q             (in_q),
		.batch_end        (batch_end),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pop_ok           (pop_ok),
		.underrun         (underrun),
		.even_i           (even_i),
		.even_q           (even_q),
		.odd_i            (odd_i),
		.odd_q            (odd_q),
		.last             (last),
		.dropped_now      (dropped_now),
		.batch_dropped    (batch_dropped),
		.fill_level       (fill_level),
		.lifetime_dropped (lifetime_dropped)
	);

endmodule
`default_nettype wire

@@ sv/dofifo_chk.sv @@
`default_nettype none
module dofifo_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic [1:0]                         mode,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic                               pop_ok,
	input wire logic                               underrun,
	input wire logic signed [dofifo_pkg::IQ_W-1:0] even_i,
	input wire logic signed [dofifo_pkg::IQ_W-1:0] even_q,
	input wire logic signed [dofifo_pkg::IQ_W-1:0] odd_i,
	input wire logic signed [dofifo_pkg::IQ_W-1:0] odd_q,
	input wire logic                               last,
	input wire logic                               dropped_now
);

	// a push transaction shows its single result on the next cycle
	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == dofifo_pkg::MODE_PUSH)
		|=> out_valid && last && !pop_ok && !underrun)
		else $error("push did not give a single result");

	// results without samples are single and carry zero samples
	a_no_samples: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pop_ok
		|-> last && (even_i == '0) && (even_q == '0) && (odd_i == '0) && (odd_q == '0))
		else $error("non-pop result carries samples or is not last");

	a_pop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pop_ok |-> !underrun && !dropped_now)
		else $error("pop result flagged as underrun or drop");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(even_i) && $stable(last))
		else $error("stalled result changed");

endmodule

bind drop_oldest_iq_block_fifo_core dofifo_chk u_dofifo_chk (.*);
`default_nettype wire
